[design/expression_language_lexer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the expression language lexer
// Shorthand for clocked concurrent checks held off during reset.
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_LANGUAGE_LEXER_ASSERT_SVH
`define EXPRESSION_LANGUAGE_LEXER_ASSERT_SVH

// plain condition, checked every edge
`define ELL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// same-cycle implication
`define ELL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ELL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ell_pkg.sv]
// ----------------------------------------------------------------------------
// ell_pkg
// Types and constants shared by the lexer front end, back end and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ell_pkg;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_INT   = 5'b00010,
    MODE_DOT   = 5'b00100,
    MODE_FRAC  = 5'b01000,
    MODE_IDENT = 5'b10000
  } mode_e;

  localparam logic [3:0] KIND_NUMBER = 4'd8;
  localparam logic [3:0] KIND_IDENT  = 4'd9;
  localparam logic [3:0] KIND_LET    = 4'd10;
  localparam logic [3:0] KIND_PRINT  = 4'd11;
  localparam logic [3:0] KIND_END    = 4'd12;
  localparam logic [3:0] KIND_BAD    = 4'd13;

  localparam logic [3:0] KW_NONE  = 4'd0;
  localparam logic [3:0] KW_L     = 4'd1;
  localparam logic [3:0] KW_LE    = 4'd2;
  localparam logic [3:0] KW_LET   = 4'd3;
  localparam logic [3:0] KW_P     = 4'd4;
  localparam logic [3:0] KW_PR    = 4'd5;
  localparam logic [3:0] KW_PRI   = 4'd6;
  localparam logic [3:0] KW_PRIN  = 4'd7;
  localparam logic [3:0] KW_PRINT = 4'd8;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_LC_I   = 8'h69;
  localparam logic [7:0] CH_LC_L   = 8'h6C;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_P   = 8'h70;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;

  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int MAX_RES   = 4;
  localparam int NSLOT     = 6;
  localparam int RES_IDX_W = $clog2(MAX_RES);
  localparam int RES_CNT_W = $clog2(NSLOT + 1);

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       digit;
    logic       alpha;
    logic       dot;
    logic       nl;
    logic       blank;
    logic       op;
    logic [2:0] op_idx;
  } item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic [7:0]  bad;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t a;
    res_t b;
    logic va;
    logic vb;
  } flush_t;

endpackage

`default_nettype wire

[design/ell_front.sv]
// ----------------------------------------------------------------------------
// ell_front
// Accepts source bytes, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ell_front import ell_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire logic  [7:0] ch_i,
  input  wire logic  fin_i,
  output logic       full_o,
  output logic       q_valid_o,
  output item_t      q_item_o,
  input  wire logic  q_take_i
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  item_t             cls;
  logic              wr_en;

  always_comb begin
    cls        = '0;
    cls.ch     = ch_i;
    cls.fin    = fin_i;
    cls.digit  = (ch_i >= 8'h30) && (ch_i <= 8'h39);
    cls.alpha  = ((ch_i >= 8'h61) && (ch_i <= 8'h7A)) || ((ch_i >= 8'h41) && (ch_i <= 8'h5A));
    cls.dot    = (ch_i == CH_DOT);
    cls.nl     = (ch_i == CH_NL);
    cls.blank  = (ch_i == CH_SPACE) || (ch_i == CH_CR) || (ch_i == CH_TAB);
    cls.op     = 1'b1;
    unique case (ch_i)
      CH_LPAREN: cls.op_idx = 3'd0;
      CH_RPAREN: cls.op_idx = 3'd1;
      CH_PLUS:   cls.op_idx = 3'd2;
      CH_MINUS:  cls.op_idx = 3'd3;
      CH_STAR:   cls.op_idx = 3'd4;
      CH_SLASH:  cls.op_idx = 3'd5;
      CH_EQUAL:  cls.op_idx = 3'd6;
      CH_SEMI:   cls.op_idx = 3'd7;
      default: begin
        cls.op     = 1'b0;
        cls.op_idx = 3'd0;
      end
    endcase
  end

  assign full_o    = (cnt_q == QCNT_W'(QDEPTH));
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_q];
  assign wr_en     = push_i && !full_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (q_take_i) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(wr_en) - QCNT_W'(q_take_i);
    end
  end

endmodule

`default_nettype wire

[design/ell_back.sv]
// ----------------------------------------------------------------------------
// ell_back
// Scanner state machine: turns classified bytes into tokens, buffers the
// burst of one byte and hands results out through an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "expression_language_lexer_assert.svh"

module ell_back import ell_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  q_valid_i,
  input  wire item_t q_item_i,
  output logic       q_take_o,
  output logic       out_valid_o,
  output res_t       out_res_o,
  input  wire logic  pop_i
);

  localparam int W = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  mode_e                  mode_q, mode_a, mode_b;
  logic [3:0]             kw_q, kw_a, kw_b;
  logic [OFFSET_BITS-1:0] start_q, start_b;
  logic [OFFSET_BITS-1:0] pos_q, pos_n;
  logic [15:0]            line_q, line_b;

  res_t                   rbuf_q [MAX_RES];
  res_t                   rbuf_d [MAX_RES];
  logic [RES_IDX_W-1:0]   idx_q;
  logic [RES_CNT_W-1:0]   rem_q, cnt;
  res_t                   out_q;
  logic                   out_v_q;

  res_t                   slot [NSLOT];
  logic [NSLOT-1:0]       sv;
  flush_t                 fl_a, fl_b;
  logic                   taken, move, load;
  item_t                  it;

  function automatic logic [15:0] low16(input logic [OFFSET_BITS-1:0] v);
    logic [W-1:0] e;
    e = W'(v);
    return e[15:0];
  endfunction

  function automatic logic [15:0] sat_len(input logic [OFFSET_BITS-1:0] e,
                                          input logic [OFFSET_BITS-1:0] s);
    logic [OFFSET_BITS-1:0] d;
    logic [W-1:0]           x;
    d = (e >= s) ? e - s : '0;
    x = W'(d);
    return (x > W'(16'hFFFF)) ? 16'hFFFF : x[15:0];
  endfunction

  function automatic res_t mk_res(input logic [3:0] kind, input logic [OFFSET_BITS-1:0] st,
                                  input logic [15:0] len, input logic [15:0] ln,
                                  input logic [7:0] bad);
    res_t r;
    r.kind   = kind;
    r.start  = low16(st);
    r.length = len;
    r.line   = ln;
    r.bad    = bad;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic logic [3:0] kw_next(input logic [3:0] k, input logic [7:0] c);
    logic [3:0] n;
    n = KW_NONE;
    unique case (k)
      KW_L:    if (c == CH_LC_E) n = KW_LE;
      KW_LE:   if (c == CH_LC_T) n = KW_LET;
      KW_P:    if (c == CH_LC_R) n = KW_PR;
      KW_PR:   if (c == CH_LC_I) n = KW_PRI;
      KW_PRI:  if (c == CH_LC_N) n = KW_PRIN;
      KW_PRIN: if (c == CH_LC_T) n = KW_PRINT;
      default: n = KW_NONE;
    endcase
    return n;
  endfunction

  function automatic flush_t do_flush(input mode_e m, input logic [3:0] kw,
                                      input logic [OFFSET_BITS-1:0] st,
                                      input logic [OFFSET_BITS-1:0] off,
                                      input logic [15:0] ln);
    flush_t                 f;
    logic [OFFSET_BITS-1:0] dot;
    logic [3:0]             ik;
    f   = '0;
    dot = (off != '0) ? off - OFFSET_BITS'(1) : '0;
    ik  = (kw == KW_LET) ? KIND_LET : (kw == KW_PRINT) ? KIND_PRINT : KIND_IDENT;
    unique case (m)
      MODE_INT, MODE_FRAC: begin
        f.va = 1'b1;
        f.a  = mk_res(KIND_NUMBER, st, sat_len(off, st), ln, 8'h00);
      end
      MODE_DOT: begin
        f.va = 1'b1;
        f.a  = mk_res(KIND_NUMBER, st, sat_len(dot, st), ln, 8'h00);
        f.vb = 1'b1;
        f.b  = mk_res(KIND_BAD, dot, 16'd1, ln, CH_DOT);
      end
      MODE_IDENT: begin
        f.va = 1'b1;
        f.a  = mk_res(ik, st, sat_len(off, st), ln, 8'h00);
      end
      default: ;
    endcase
    return f;
  endfunction

  assign it = q_item_i;

  always_comb begin
    taken  = 1'b0;
    mode_a = mode_q;
    kw_a   = kw_q;
    unique case (mode_q)
      MODE_INT: begin
        if (it.digit) begin
          taken = 1'b1;
        end else if (it.dot) begin
          mode_a = MODE_DOT;
          taken  = 1'b1;
        end
      end
      MODE_DOT: begin
        if (it.digit) begin
          mode_a = MODE_FRAC;
          taken  = 1'b1;
        end
      end
      MODE_FRAC: begin
        if (it.digit) taken = 1'b1;
      end
      MODE_IDENT: begin
        if (it.digit || it.alpha) begin
          kw_a  = kw_next(kw_q, it.ch);
          taken = 1'b1;
        end
      end
      default: ;
    endcase

    fl_a    = do_flush(mode_q, kw_q, start_q, pos_q, line_q);
    mode_b  = mode_a;
    kw_b    = kw_a;
    start_b = start_q;
    line_b  = line_q;
    slot[2] = mk_res(KIND_BAD, pos_q, 16'd1, line_q, it.ch);
    sv[2]   = 1'b0;
    if (!taken) begin
      mode_b  = MODE_IDLE;
      start_b = pos_q;
      if (it.op) begin
        sv[2]   = 1'b1;
        slot[2] = mk_res({1'b0, it.op_idx}, pos_q, 16'd1, line_q, 8'h00);
      end else if (it.digit) begin
        mode_b = MODE_INT;
      end else if (it.alpha) begin
        mode_b = MODE_IDENT;
        kw_b   = (it.ch == CH_LC_L) ? KW_L : (it.ch == CH_LC_P) ? KW_P : KW_NONE;
      end else if (it.nl) begin
        if (line_q != 16'hFFFF) line_b = line_q + 16'd1;
      end else if (!it.blank) begin
        sv[2] = 1'b1;
      end
    end
    slot[0] = fl_a.a;
    slot[1] = fl_a.b;
    sv[0]   = !taken && fl_a.va;
    sv[1]   = !taken && fl_a.vb;

    pos_n   = (pos_q == POS_MAX) ? pos_q : pos_q + OFFSET_BITS'(1);
    fl_b    = do_flush(mode_b, kw_b, start_b, pos_n, line_b);
    slot[3] = fl_b.a;
    slot[4] = fl_b.b;
    slot[5] = mk_res(KIND_END, pos_n, 16'd0, line_b, 8'h00);
    sv[3]   = it.fin && fl_b.va;
    sv[4]   = it.fin && fl_b.vb;
    sv[5]   = it.fin;

    // pack the valid slots in order
    rbuf_d = rbuf_q;
    cnt    = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (sv[i]) begin
        if (cnt < RES_CNT_W'(MAX_RES)) rbuf_d[cnt[RES_IDX_W-1:0]] = slot[i];
        cnt = cnt + RES_CNT_W'(1);
      end
    end
    for (int i = 0; i < MAX_RES; i++) begin
      rbuf_d[i].last = (RES_CNT_W'(i) == cnt - RES_CNT_W'(1));
    end
  end

  assign move        = (rem_q != '0) && (!out_v_q || pop_i);
  assign load        = q_valid_i && ((rem_q == '0) || ((rem_q == RES_CNT_W'(1)) && move));
  assign q_take_o    = load;
  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      rbuf_q <= rbuf_d;
    end
    if (move) begin
      out_q <= rbuf_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      kw_q    <= KW_NONE;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= 16'd1;
      rem_q   <= '0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (load) begin
        if (it.fin) begin
          mode_q  <= MODE_IDLE;
          kw_q    <= KW_NONE;
          start_q <= '0;
          pos_q   <= '0;
          line_q  <= 16'd1;
        end else begin
          mode_q  <= mode_b;
          kw_q    <= kw_b;
          start_q <= start_b;
          pos_q   <= pos_n;
          line_q  <= line_b;
        end
        rem_q <= cnt;
        idx_q <= '0;
      end else if (move) begin
        rem_q <= rem_q - RES_CNT_W'(1);
        idx_q <= idx_q + RES_IDX_W'(1);
      end
      out_v_q <= move || (out_v_q && !pop_i);
    end
  end

  `ELL_ASSERT(a_rem_range, rem_q <= RES_CNT_W'(MAX_RES), "result buffer count out of range")
  `ELL_ASSERT_IMP(a_last_flag, move && (rem_q == RES_CNT_W'(1)), rbuf_q[idx_q].last, "final result of a byte lacks last flag")
  `ELL_ASSERT_NXT(a_fin_reset, load && it.fin, (mode_q == MODE_IDLE) && (pos_q == '0) && (line_q == 16'd1), "scan state not cleared after final byte")
  `ELL_ASSERT_NXT(a_out_hold, out_v_q && !pop_i, out_v_q && $stable(out_q), "waiting result changed while stalled")

endmodule

`default_nettype wire

[design/expression_language_lexer.sv]
// Path: front queue, result buffer, output register. Throughput: one byte per
// cycle while each byte yields at most one token and pop keeps the output
// drained; a byte that yields more (at most four) holds the scanner until its
// last result moves out, as the result buffer drains one per cycle while popped.
// Reset: asynchronous, clears scan state, queues and output at once.
// ----------------------------------------------------------------------------
// expression_language_lexer
// Streaming lexer: source bytes in, tokens as kind, offset, length and line out.
// ----------------------------------------------------------------------------
`default_nettype none

module expression_language_lexer import ell_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  ch_i,
  input  wire logic        final_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       token_kind_o,
  output logic [15:0]      token_start_o,
  output logic [15:0]      token_length_o,
  output logic [15:0]      line_number_o,
  output logic [7:0]       bad_byte_o,
  output logic             last_of_run_o
);

  logic  q_valid, q_take, out_valid;
  item_t q_item;
  res_t  out_res;

  ell_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .ch_i      (ch_i),
    .fin_i     (final_byte_i),
    .full_o    (full),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_take_i  (q_take)
  );

  ell_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_take_o    (q_take),
    .out_valid_o (out_valid),
    .out_res_o   (out_res),
    .pop_i       (pop)
  );

  assign empty          = !out_valid;
  assign token_kind_o   = out_res.kind;
  assign token_start_o  = out_res.start;
  assign token_length_o = out_res.length;
  assign line_number_o  = out_res.line;
  assign bad_byte_o     = out_res.bad;
  assign last_of_run_o  = out_res.last;

endmodule

`default_nettype wire

[verif/expression_language_lexer_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// expression_language_lexer_check
// Watches the byte and token channels of the lexer. Each accepted byte runs
// through a scanner model that queues the tokens it should produce. Each
// popped token is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------

module expression_language_lexer_check import ell_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  ch_i,
  input  logic        final_byte_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [3:0]  token_kind_i,
  input  logic [15:0] token_start_i,
  input  logic [15:0] token_length_i,
  input  logic [15:0] line_number_i,
  input  logic [7:0]  bad_byte_i,
  input  logic        last_of_run_i,
  output int          fail_count_o,
  output int          outstanding_o
);

  localparam longint POS_MAX = (longint'(1) << OFFSET_BITS) - 1;

  localparam logic [3:0] KIND_LPAREN = 4'd0;
  localparam logic [3:0] KIND_RPAREN = 4'd1;
  localparam logic [3:0] KIND_PLUS   = 4'd2;
  localparam logic [3:0] KIND_MINUS  = 4'd3;
  localparam logic [3:0] KIND_STAR   = 4'd4;
  localparam logic [3:0] KIND_SLASH  = 4'd5;
  localparam logic [3:0] KIND_EQUAL  = 4'd6;
  localparam logic [3:0] KIND_SEMI   = 4'd7;

  mode_e      scan_mode;
  longint     tok_start;
  longint     scan_pos;
  logic [15:0] line_cnt;
  logic [3:0]  kw_state;

  res_t tokens_q[$];
  res_t step_q[$];
  int   mismatches;
  int   outstanding;

  assign fail_count_o  = mismatches;
  assign outstanding_o = outstanding;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit op_kind(input logic [7:0] c, output logic [3:0] kind);
    kind = KIND_LPAREN;
    case (c)
      CH_LPAREN: kind = KIND_LPAREN;
      CH_RPAREN: kind = KIND_RPAREN;
      CH_PLUS:   kind = KIND_PLUS;
      CH_MINUS:  kind = KIND_MINUS;
      CH_STAR:   kind = KIND_STAR;
      CH_SLASH:  kind = KIND_SLASH;
      CH_EQUAL:  kind = KIND_EQUAL;
      CH_SEMI:   kind = KIND_SEMI;
      default:   return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [3:0] kw_step(input logic [3:0] k, input logic [7:0] c);
    if (k == KW_L    && c == CH_LC_E) return KW_LE;
    if (k == KW_LE   && c == CH_LC_T) return KW_LET;
    if (k == KW_P    && c == CH_LC_R) return KW_PR;
    if (k == KW_PR   && c == CH_LC_I) return KW_PRI;
    if (k == KW_PRI  && c == CH_LC_N) return KW_PRIN;
    if (k == KW_PRIN && c == CH_LC_T) return KW_PRINT;
    return KW_NONE;
  endfunction

  task reset_scan();
    scan_mode = MODE_IDLE;
    tok_start = 0;
    scan_pos  = 0;
    line_cnt  = 16'd1;
    kw_state  = KW_NONE;
  endtask

  task add_token(input logic [3:0] kind, input longint s, input longint e,
                 input logic [7:0] bad);
    res_t   r;
    longint len;
    if (step_q.size() < MAX_RES) begin
      len = (e >= s) ? e - s : 0;
      if (len > 65535) len = 65535;
      r.kind   = kind;
      r.start  = s[15:0];
      r.length = len[15:0];
      r.line   = line_cnt;
      r.bad    = bad;
      r.last   = 1'b0;
      step_q.insert(step_q.size(), r);
    end
  endtask

  task flush_token(input longint off);
    longint dot;
    dot = (off > 0) ? off - 1 : 0;
    case (scan_mode)
      MODE_INT, MODE_FRAC: add_token(KIND_NUMBER, tok_start, off, 8'h00);
      MODE_DOT: begin
        add_token(KIND_NUMBER, tok_start, dot, 8'h00);
        add_token(KIND_BAD, dot, dot + 1, CH_DOT);
      end
      MODE_IDENT: begin
        if (kw_state == KW_LET) add_token(KIND_LET, tok_start, off, 8'h00);
        else if (kw_state == KW_PRINT) add_token(KIND_PRINT, tok_start, off, 8'h00);
        else add_token(KIND_IDENT, tok_start, off, 8'h00);
      end
      default: ;
    endcase
    scan_mode = MODE_IDLE;
  endtask

  task scan_byte(input logic [7:0] c, input logic f);
    longint     off;
    bit         taken;
    logic [3:0] op;
    step_q.delete();
    off   = scan_pos;
    taken = 1'b0;
    case (scan_mode)
      MODE_INT: begin
        if (is_digit(c)) taken = 1'b1;
        else if (c == CH_DOT) begin
          scan_mode = MODE_DOT;
          taken = 1'b1;
        end
      end
      MODE_DOT: begin
        if (is_digit(c)) begin
          scan_mode = MODE_FRAC;
          taken = 1'b1;
        end
      end
      MODE_FRAC: if (is_digit(c)) taken = 1'b1;
      MODE_IDENT: begin
        if (is_digit(c) || is_alpha(c)) begin
          kw_state = kw_step(kw_state, c);
          taken = 1'b1;
        end
      end
      default: ;
    endcase
    if (!taken) begin
      flush_token(off);
      tok_start = off;
      if (op_kind(c, op)) add_token(op, off, off + 1, 8'h00);
      else if (is_digit(c)) scan_mode = MODE_INT;
      else if (is_alpha(c)) begin
        scan_mode = MODE_IDENT;
        kw_state = (c == CH_LC_L) ? KW_L : (c == CH_LC_P) ? KW_P : KW_NONE;
      end else if (c == CH_NL) begin
        if (line_cnt != 16'hFFFF) line_cnt = line_cnt + 16'd1;
      end else if (c != CH_SPACE && c != CH_CR && c != CH_TAB) begin
        add_token(KIND_BAD, off, off + 1, c);
      end
    end
    if (scan_pos < POS_MAX) scan_pos = scan_pos + 1;
    if (f) begin
      flush_token(scan_pos);
      add_token(KIND_END, scan_pos, scan_pos, 8'h00);
      reset_scan();
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) tokens_q.insert(tokens_q.size(), step_q[i]);
    outstanding = outstanding + step_q.size();
  endtask

  task check_token();
    res_t exp_r;
    if (tokens_q.size() == 0) begin
      if (mismatches < 10)
        $display("[%0t] token kind %0d start %0d popped with none expected",
                 $realtime, token_kind_i, token_start_i);
      mismatches = mismatches + 1;
    end else begin
      exp_r = tokens_q.pop_front();
      outstanding = outstanding - 1;
      if (exp_r.kind !== token_kind_i || exp_r.start !== token_start_i ||
          exp_r.length !== token_length_i || exp_r.line !== line_number_i ||
          exp_r.bad !== bad_byte_i || exp_r.last !== last_of_run_i) begin
        if (mismatches < 10) begin
          $write("[%0t] token mismatch exp/got: kind %0d/%0d start %0d/%0d",
                 $realtime, exp_r.kind, token_kind_i, exp_r.start, token_start_i);
          $display(" len %0d/%0d line %0d/%0d bad %0h/%0h last %0b/%0b",
                   exp_r.length, token_length_i, exp_r.line, line_number_i,
                   exp_r.bad, bad_byte_i, exp_r.last, last_of_run_i);
        end
        mismatches = mismatches + 1;
      end
    end
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
    reset_scan();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_scan();
      tokens_q.delete();
      outstanding = 0;
    end else begin
      if (pop_i && !empty_i) check_token();
      if (push_i && !full_i) scan_byte(ch_i, final_byte_i);
    end
  end

endmodule

[verif/expression_language_lexer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// expression_language_lexer_test
// Feeds source text to the lexer byte by byte: a directed set of sources,
// then random sources built from token fragments and noise. Both sides
// stall in short random bursts, but not in the quiet tail of the random
// bytes; the checker beside the block scores every token.
// ----------------------------------------------------------------------------

module expression_language_lexer_test import ell_pkg::*; ();

  localparam int OFFSET_BITS  = 16;
  localparam int CYCLE_LIMIT  = 20_000;
  localparam int RANDOM_BYTES = 105;
  localparam int QUIET_BYTES  = 30;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push   = 1'b0;
  logic        full;
  logic [7:0]  ch     = 8'h00;
  logic        fin    = 1'b0;
  logic        empty;
  logic        pop    = 1'b0;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] line_number;
  logic [7:0]  bad_byte;
  logic        last_of_run;
  int          fail_count;
  int          outstanding;

  bit          idle_on = 1'b0;
  int          pop_stall = 0;
  int          bytes_sent = 0;
  logic [7:0]  src_q[$];

  expression_language_lexer #(.OFFSET_BITS(OFFSET_BITS)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .ch_i           (ch),
    .final_byte_i   (fin),
    .empty          (empty),
    .pop            (pop),
    .token_kind_o   (token_kind),
    .token_start_o  (token_start),
    .token_length_o (token_length),
    .line_number_o  (line_number),
    .bad_byte_o     (bad_byte),
    .last_of_run_o  (last_of_run)
  );

  expression_language_lexer_check #(.OFFSET_BITS(OFFSET_BITS)) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .ch_i           (ch),
    .final_byte_i   (fin),
    .empty_i        (empty),
    .pop_i          (pop),
    .token_kind_i   (token_kind),
    .token_start_i  (token_start),
    .token_length_i (token_length),
    .line_number_i  (line_number),
    .bad_byte_i     (bad_byte),
    .last_of_run_i  (last_of_run),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("expression_language_lexer verification failed");
    $finish;
  end

  // token side: pop held low in short bursts while idling is on
  initial begin
    forever begin
      @(negedge clk_i);
      if (pop_stall > 0) begin
        pop <= 1'b0;
        pop_stall = pop_stall - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        pop_stall = $urandom_range(1, 3) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic f);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk_i);
        push <= 1'b0;
      end
    end
    @(negedge clk_i);
    push <= 1'b1;
    ch   <= c;
    fin  <= f;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic send_source();
    for (int i = 0; i < src_q.size(); i++) send_byte(src_q[i], i == src_q.size() - 1);
    bytes_sent = bytes_sent + src_q.size();
    src_q.delete();
  endtask

  task automatic add_byte(input logic [7:0] b);
    src_q.insert(src_q.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_digits(input int n);
    repeat (n) add_byte(8'h30 + 8'($urandom_range(0, 9)));
  endtask

  function automatic logic [7:0] rand_alnum();
    case ($urandom_range(0, 2))
      0:       return 8'h30 + 8'($urandom_range(0, 9));
      1:       return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  task automatic add_fragment();
    case ($urandom_range(0, 12))
      0: add_digits($urandom_range(1, 4));
      1: begin
        add_digits($urandom_range(1, 3));
        add_byte(CH_DOT);
        add_digits($urandom_range(1, 3));
      end
      2: begin
        add_digits($urandom_range(1, 2));
        add_byte(CH_DOT);
      end
      3: begin
        add_byte($urandom_range(0, 1) ? 8'h61 + 8'($urandom_range(0, 25))
                                      : 8'h41 + 8'($urandom_range(0, 25)));
        repeat ($urandom_range(0, 4)) add_byte(rand_alnum());
      end
      4: add_text("let");
      5: add_text("print");
      6: begin
        case ($urandom_range(0, 5))
          0:       add_text("l");
          1:       add_text("le");
          2:       add_text("lets");
          3:       add_text("pri");
          4:       add_text("print2");
          default: add_text("prInt");
        endcase
      end
      7: begin
        case ($urandom_range(0, 7))
          0:       add_byte(CH_LPAREN);
          1:       add_byte(CH_RPAREN);
          2:       add_byte(CH_PLUS);
          3:       add_byte(CH_MINUS);
          4:       add_byte(CH_STAR);
          5:       add_byte(CH_SLASH);
          6:       add_byte(CH_EQUAL);
          default: add_byte(CH_SEMI);
        endcase
      end
      8: begin
        case ($urandom_range(0, 2))
          0:       add_byte(CH_SPACE);
          1:       add_byte(CH_TAB);
          default: add_byte(CH_CR);
        endcase
      end
      9:  add_byte(CH_NL);
      10: add_byte(8'($urandom_range(0, 255)));
      11: add_byte(CH_DOT);
      default: add_byte(8'($urandom_range(128, 255)));
    endcase
    if ($urandom_range(0, 2) == 0) add_byte(CH_SPACE);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_on = 1'b1;

    // every operator, a fraction, a keyword and an identifier
    add_text("let v=(1.5-p)*9/3+2;");
    send_source();
    // dot not followed by a digit, then a token flushed by the final byte
    add_text("8.q");
    send_source();
    add_byte(8'hFF);
    send_source();
    // source ends on a pending dot
    add_text("5.");
    send_source();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      idle_on = bytes_sent < RANDOM_BYTES - QUIET_BYTES;
      repeat ($urandom_range(1, 5)) add_fragment();
      send_source();
    end
    idle_on = 1'b0;

    @(negedge clk_i);
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("expression_language_lexer verification clean");
    end else begin
      $display("expression_language_lexer verification failed");
    end
    $finish;
  end

endmodule
